[design/vbvp_pkg.sv]
`default_nettype none
package vbvp_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = Q_W + FRAC_W;
    localparam int DEN_W     = Q_W - 1;

    localparam logic signed [Q_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MINV = 32'sh8000_0000;

    localparam logic REG_ALIGN_MODE    = 1'b0;
    localparam logic REG_MEET_OR_SLICE = 1'b1;

    localparam logic [3:0] ALIGN_RESET = 4'd5;

    typedef enum logic [1:0] {
        POS_MIN = 2'd0,
        POS_MID = 2'd1,
        POS_MAX = 2'd2
    } t_pos;

    typedef struct packed {
        logic aligned;
        t_pos xpos;
        t_pos ypos;
    } t_align;

    typedef struct packed {
        logic signed [Q_W-1:0] elem_x;
        logic signed [Q_W-1:0] elem_y;
        logic signed [Q_W-1:0] elem_width;
        logic signed [Q_W-1:0] elem_height;
        logic signed [Q_W-1:0] view_x;
        logic signed [Q_W-1:0] view_y;
        logic signed [Q_W-1:0] view_width;
        logic signed [Q_W-1:0] view_height;
        logic                  normalize;
    } t_item;

    typedef struct packed {
        logic view_valid;
        logic xa;
        logic ya;
        logic xmid;
        logic ymid;
        logic donorm;
    } t_ctl;

    typedef struct packed {
        logic                  donorm;
        logic                  view_valid;
        logic                  flag;
        logic signed [Q_W-1:0] sx;
        logic signed [Q_W-1:0] sy;
        logic signed [Q_W-1:0] tx;
        logic signed [Q_W-1:0] ty;
    } t_pre;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DIV_STEPS-1:0] dq;
    } t_dstep;

    typedef struct packed {
        logic signed [Q_W-1:0] val;
        logic                  clip;
    } t_sat;

    function automatic t_align decode_align(input logic [3:0] am);
        t_align a;
        a = '{aligned: 1'b1, xpos: POS_MIN, ypos: POS_MIN};
        unique case (am)
            4'd1: begin a.xpos = POS_MIN; a.ypos = POS_MIN; end
            4'd2: begin a.xpos = POS_MID; a.ypos = POS_MIN; end
            4'd3: begin a.xpos = POS_MAX; a.ypos = POS_MIN; end
            4'd4: begin a.xpos = POS_MIN; a.ypos = POS_MID; end
            4'd5: begin a.xpos = POS_MID; a.ypos = POS_MID; end
            4'd6: begin a.xpos = POS_MAX; a.ypos = POS_MID; end
            4'd7: begin a.xpos = POS_MIN; a.ypos = POS_MAX; end
            4'd8: begin a.xpos = POS_MID; a.ypos = POS_MAX; end
            4'd9: begin a.xpos = POS_MAX; a.ypos = POS_MAX; end
            default: a.aligned = 1'b0;
        endcase
        return a;
    endfunction

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat s;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            s.val  = Q_MAXV;
            s.clip = 1'b1;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            s.val  = Q_MINV;
            s.clip = 1'b1;
        end else begin
            s.val  = v[Q_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

    function automatic t_dstep div_step(input t_dstep s, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t_dstep n;
        t = {s.rem, s.dq[DIV_STEPS-1]};
        if (t >= {1'b0, den}) begin
            n.rem = DEN_W'(t - {1'b0, den});
            n.dq  = {s.dq[DIV_STEPS-2:0], 1'b1};
        end else begin
            n.rem = t[DEN_W-1:0];
            n.dq  = {s.dq[DIV_STEPS-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[design/viewbox_to_viewport_transform_unit.sv]
`default_nettype none
// Computes the SVG view box to viewport scale and translate in signed Q16.16 with
// saturation. One item is taken every cycle while the output is not stalled. The pipe is
// built from two 48-stage pipelined dividers, one for the axis scales and one for the
// optional normalization, with five fixed-point stages between them and one output
// register. A stall freezes the whole pipe.
module viewbox_to_viewport_transform_unit
    import vbvp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic                  i_cfg_addr,
    input  wire logic [3:0]            i_cfg_wr_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [Q_W-1:0] i_elem_x,
    input  wire logic signed [Q_W-1:0] i_elem_y,
    input  wire logic signed [Q_W-1:0] i_elem_width,
    input  wire logic signed [Q_W-1:0] i_elem_height,
    input  wire logic signed [Q_W-1:0] i_view_x,
    input  wire logic signed [Q_W-1:0] i_view_y,
    input  wire logic signed [Q_W-1:0] i_view_width,
    input  wire logic signed [Q_W-1:0] i_view_height,
    input  wire logic                  i_normalize,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [Q_W-1:0]      o_scale_x,
    output logic signed [Q_W-1:0]      o_scale_y,
    output logic signed [Q_W-1:0]      o_shift_x,
    output logic signed [Q_W-1:0]      o_shift_y,
    output logic                       o_view_valid,
    output logic                       o_saturated
);

    logic [3:0] r_align_mode;
    logic       r_meet_or_slice;
    logic       en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_mode    <= ALIGN_RESET;
            r_meet_or_slice <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_ALIGN_MODE:    r_align_mode    <= i_cfg_wr_data;
                REG_MEET_OR_SLICE: r_meet_or_slice <= i_cfg_wr_data[0];
                default:           r_align_mode    <= r_align_mode;
            endcase
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    t_item in_item;
    logic  in_vv;
    logic [1:0][Q_W-1:0] d1_num, d1_den, d1_quot;
    logic [1:0]          d1_sat;
    logic                d1_v;
    t_item               d1_item;
    logic                d1_vv;

    assign in_item = '{elem_x: i_elem_x, elem_y: i_elem_y, elem_width: i_elem_width,
                       elem_height: i_elem_height, view_x: i_view_x, view_y: i_view_y,
                       view_width: i_view_width, view_height: i_view_height,
                       normalize: i_normalize};
    assign in_vv  = (i_view_width > 0) && (i_view_height > 0);
    assign d1_num = {i_elem_height, i_elem_width};
    assign d1_den = {(i_view_height > 0) ? i_view_height : Q_ONE,
                     (i_view_width  > 0) ? i_view_width  : Q_ONE};

    vbvp_div #(.LANES(2), .SB_W($bits(t_item) + 1)) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_sb    ({in_vv, in_item}),
        .o_valid (d1_v),
        .o_quot  (d1_quot),
        .o_sat   (d1_sat),
        .o_sb    ({d1_vv, d1_item})
    );

    t_align al;
    logic signed [Q_W-1:0] qx, qy, u, n_sx, n_sy;
    t_ctl n_ctl;

    always_comb begin
        al = decode_align(r_align_mode);
        qx = $signed(d1_quot[0]);
        qy = $signed(d1_quot[1]);
        if (!r_meet_or_slice) begin
            u = (qx < qy) ? qx : qy;
        end else begin
            u = (qx > qy) ? qx : qy;
        end
        n_sx = d1_vv ? (al.aligned ? u : qx) : Q_ONE;
        n_sy = d1_vv ? (al.aligned ? u : qy) : Q_ONE;
        n_ctl.view_valid = d1_vv;
        n_ctl.xa     = d1_vv && al.aligned && (al.xpos != POS_MIN);
        n_ctl.ya     = d1_vv && al.aligned && (al.ypos != POS_MIN);
        n_ctl.xmid   = al.xpos == POS_MID;
        n_ctl.ymid   = al.ypos == POS_MID;
        n_ctl.donorm = d1_item.normalize && (d1_item.elem_width > 0)
                       && (d1_item.elem_height > 0);
    end

    logic                  r2_v, r3_v, r4_v, r5_v, r6_v;
    t_item                 r2_item, r3_item, r4_item;
    t_ctl                  r2_ctl, r3_ctl, r4_ctl, r5_ctl, r6_ctl;
    logic                  r2_flag, r3_flag, r4_flag, r5_flag, r6_flag;
    logic signed [Q_W-1:0] r2_sx, r2_sy, r3_sx, r3_sy, r4_sx, r4_sy, r5_sx, r5_sy;
    logic signed [Q_W-1:0] r6_sx, r6_sy;
    logic signed [63:0]    r3_pvx, r3_pvy, r3_pvw, r3_pvh;
    logic signed [Q_W-1:0] r4_mx, r4_my, r4_mw, r4_mh, r5_mw, r5_mh, r6_mw, r6_mh;
    logic signed [Q_W-1:0] r5_tx, r5_ty, r5_dx, r5_dy, r6_tx, r6_ty;
    logic signed [Q_W-1:0] r5_ew, r5_eh, r6_ew, r6_eh;

    t_sat s_mx, s_my, s_mw, s_mh, s_tx, s_ty, s_dx, s_dy, s_ax, s_ay;
    logic signed [Q_W-1:0] hx, hy;

    always_comb begin
        s_mx = sat32(r3_pvx >>> FRAC_W);
        s_my = sat32(r3_pvy >>> FRAC_W);
        s_mw = sat32(r3_pvw >>> FRAC_W);
        s_mh = sat32(r3_pvh >>> FRAC_W);
        s_tx = sat32(64'(r4_item.elem_x) - 64'(r4_mx));
        s_ty = sat32(64'(r4_item.elem_y) - 64'(r4_my));
        s_dx = sat32(64'(r4_item.elem_width) - 64'(r4_mw));
        s_dy = sat32(64'(r4_item.elem_height) - 64'(r4_mh));
        hx   = r5_ctl.xmid ? (r5_dx >>> 1) : r5_dx;
        hy   = r5_ctl.ymid ? (r5_dy >>> 1) : r5_dy;
        s_ax = sat32(64'(r5_tx) + 64'(hx));
        s_ay = sat32(64'(r5_ty) + 64'(hy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r2_v <= d1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_item <= d1_item;
            r2_ctl  <= n_ctl;
            r2_flag <= d1_vv && (|d1_sat);
            r2_sx   <= n_sx;
            r2_sy   <= n_sy;

            r3_item <= r2_item;
            r3_ctl  <= r2_ctl;
            r3_flag <= r2_flag;
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;
            r3_pvx  <= r2_item.view_x * r2_sx;
            r3_pvy  <= r2_item.view_y * r2_sy;
            r3_pvw  <= r2_item.view_width * r2_sx;
            r3_pvh  <= r2_item.view_height * r2_sy;

            r4_item <= r3_item;
            r4_ctl  <= r3_ctl;
            r4_sx   <= r3_sx;
            r4_sy   <= r3_sy;
            r4_mx   <= s_mx.val;
            r4_my   <= s_my.val;
            r4_mw   <= s_mw.val;
            r4_mh   <= s_mh.val;
            r4_flag <= r3_flag
                       | (r3_ctl.view_valid & (s_mx.clip | s_my.clip))
                       | ((r3_ctl.xa | r3_ctl.donorm) & s_mw.clip)
                       | ((r3_ctl.ya | r3_ctl.donorm) & s_mh.clip);

            r5_ctl  <= r4_ctl;
            r5_sx   <= r4_sx;
            r5_sy   <= r4_sy;
            r5_mw   <= r4_mw;
            r5_mh   <= r4_mh;
            r5_ew   <= r4_item.elem_width;
            r5_eh   <= r4_item.elem_height;
            r5_tx   <= r4_ctl.view_valid ? s_tx.val : '0;
            r5_ty   <= r4_ctl.view_valid ? s_ty.val : '0;
            r5_dx   <= s_dx.val;
            r5_dy   <= s_dy.val;
            r5_flag <= r4_flag
                       | (r4_ctl.view_valid & (s_tx.clip | s_ty.clip))
                       | (r4_ctl.xa & s_dx.clip) | (r4_ctl.ya & s_dy.clip);

            r6_ctl  <= r5_ctl;
            r6_sx   <= r5_sx;
            r6_sy   <= r5_sy;
            r6_mw   <= r5_mw;
            r6_mh   <= r5_mh;
            r6_ew   <= r5_ew;
            r6_eh   <= r5_eh;
            r6_tx   <= r5_ctl.xa ? s_ax.val : r5_tx;
            r6_ty   <= r5_ctl.ya ? s_ay.val : r5_ty;
            r6_flag <= r5_flag | (r5_ctl.xa & s_ax.clip) | (r5_ctl.ya & s_ay.clip);
        end
    end

    logic [3:0][Q_W-1:0] d2_num, d2_den, d2_quot;
    logic [3:0]          d2_sat;
    logic                d2_v;
    t_pre                d2_in, d2_out;

    assign d2_num = {r6_ty, r6_tx, r6_mh, r6_mw};
    assign d2_den = r6_ctl.donorm ? {r6_eh, r6_ew, r6_eh, r6_ew} : {4{Q_ONE}};
    assign d2_in  = '{donorm: r6_ctl.donorm, view_valid: r6_ctl.view_valid, flag: r6_flag,
                      sx: r6_sx, sy: r6_sy, tx: r6_tx, ty: r6_ty};

    vbvp_div #(.LANES(4), .SB_W($bits(t_pre))) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (d2_num),
        .i_den   (d2_den),
        .i_sb    (d2_in),
        .o_valid (d2_v),
        .o_quot  (d2_quot),
        .o_sat   (d2_sat),
        .o_sb    (d2_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_scale_x    <= d2_out.donorm ? $signed(d2_quot[0]) : d2_out.sx;
            o_scale_y    <= d2_out.donorm ? $signed(d2_quot[1]) : d2_out.sy;
            o_shift_x    <= d2_out.donorm ? $signed(d2_quot[2]) : d2_out.tx;
            o_shift_y    <= d2_out.donorm ? $signed(d2_quot[3]) : d2_out.ty;
            o_view_valid <= d2_out.view_valid;
            o_saturated  <= d2_out.flag | (d2_out.donorm & (|d2_sat));
        end
    end

    a_invalid_view_no_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_view_valid |-> o_shift_x == '0 && o_shift_y == '0)
        else $error("shift is nonzero for an invalid view box");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scale_x) && $stable(o_shift_y))
        else $error("stalled result changed or was dropped");

    a_align_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && i_cfg_addr == REG_ALIGN_MODE |=> r_align_mode == $past(i_cfg_wr_data))
        else $error("alignment register write lost");

endmodule
`default_nettype wire

[design/vbvp_div.sv]
`default_nettype none
module vbvp_div
    import vbvp_pkg::*;
#(
    parameter int LANES = 2,
    parameter int SB_W  = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [LANES-1:0][Q_W-1:0] i_num,
    input  wire logic [LANES-1:0][Q_W-1:0] i_den,
    input  wire logic [SB_W-1:0]           i_sb,
    output logic                           o_valid,
    output logic [LANES-1:0][Q_W-1:0]      o_quot,
    output logic [LANES-1:0]               o_sat,
    output logic [SB_W-1:0]                o_sb
);

    logic                   r_v   [DIV_STEPS];
    t_dstep [LANES-1:0]     r_st  [DIV_STEPS];
    logic [LANES-1:0][DEN_W-1:0] r_den [DIV_STEPS];
    logic [LANES-1:0]       r_neg [DIV_STEPS];
    logic [SB_W-1:0]        r_sb  [DIV_STEPS];

    t_dstep [LANES-1:0] n_load;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_load[l].rem = '0;
            n_load[l].dq  = {(i_num[l][Q_W-1] ? Q_W'(-i_num[l]) : i_num[l]), {FRAC_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_st[0][l]  <= div_step(n_load[l], i_den[l][DEN_W-1:0]);
                r_den[0][l] <= i_den[l][DEN_W-1:0];
                r_neg[0][l] <= i_num[l][Q_W-1];
            end
            r_sb[0] <= i_sb;
            for (int k = 1; k < DIV_STEPS; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_st[k][l] <= div_step(r_st[k-1][l], r_den[k-1][l]);
                end
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    always_comb begin
        logic [DIV_STEPS-1:0] q;
        for (int l = 0; l < LANES; l++) begin
            q = r_st[DIV_STEPS-1][l].dq;
            if (!r_neg[DIV_STEPS-1][l]) begin
                o_sat[l]  = |q[DIV_STEPS-1:Q_W-1];
                o_quot[l] = o_sat[l] ? Q_MAXV : q[Q_W-1:0];
            end else begin
                o_sat[l]  = q > DIV_STEPS'(33'h0_8000_0000);
                o_quot[l] = o_sat[l] ? Q_MINV : Q_W'(-q[Q_W-1:0]);
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_sb    = r_sb[DIV_STEPS-1];

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    import vbvp_pkg::*;

    localparam int LATENCY = 102;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic signed [63:0] QONE = 64'sd65536;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               vv;
        logic               sat;
    } t_xform;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_addr;
    logic [3:0]  i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic signed [31:0] i_elem_x, i_elem_y, i_elem_width, i_elem_height;
    logic signed [31:0] i_view_x, i_view_y, i_view_width, i_view_height;
    logic        i_normalize;
    logic        o_valid;
    logic        i_stall;
    logic signed [31:0] o_scale_x, o_scale_y, o_shift_x, o_shift_y;
    logic        o_view_valid, o_saturated;

    viewbox_to_viewport_transform_unit u_top (.*);

    t_item  pending_items[$];
    t_xform expected_xforms[$];
    logic [3:0] align_cfg;
    logic       slice_cfg;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_receiver;
    int  mismatches;
    int  transforms_checked;
    int  idle_cycles;
    bit  clip_flag;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            clip_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] floor_div(input logic signed [63:0] p,
                                                     input logic signed [63:0] d);
        if (p >= 0) return p / d;
        return -((-p + d - 1) / d);
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return clip32(floor_div(a * b, QONE));
    endfunction

    function automatic logic signed [63:0] qdiv(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return clip32((a * QONE) / b);
    endfunction

    function automatic t_xform predict_xform(input t_item it);
        t_xform r;
        logic signed [63:0] ex, ey, ew, eh, vx, vy, vw, vh, sx, sy, tx, ty, u, d;
        logic aligned, valid;
        int xc, yc;
        ex = it.elem_x; ey = it.elem_y; ew = it.elem_width; eh = it.elem_height;
        vx = it.view_x; vy = it.view_y; vw = it.view_width; vh = it.view_height;
        aligned = align_cfg >= 1 && align_cfg <= 9;
        valid = vw > 0 && vh > 0;
        sx = QONE; sy = QONE; tx = 0; ty = 0;
        clip_flag = 1'b0;
        if (valid) begin
            sx = qdiv(ew, vw);
            sy = qdiv(eh, vh);
            if (aligned) begin
                if (!slice_cfg) u = (sx < sy) ? sx : sy;
                else u = (sx > sy) ? sx : sy;
                sx = u;
                sy = u;
            end
            tx = clip32(ex - qmul(vx, sx));
            ty = clip32(ey - qmul(vy, sy));
            if (aligned) begin
                xc = (align_cfg - 1) % 3;
                yc = (align_cfg - 1) / 3;
                if (xc != 0) begin
                    d = clip32(ew - qmul(vw, sx));
                    tx = clip32(tx + ((xc == 1) ? floor_div(d, 2) : d));
                end
                if (yc != 0) begin
                    d = clip32(eh - qmul(vh, sy));
                    ty = clip32(ty + ((yc == 1) ? floor_div(d, 2) : d));
                end
            end
        end
        if (it.normalize && ew > 0 && eh > 0) begin
            sx = qdiv(qmul(vw, sx), ew);
            sy = qdiv(qmul(vh, sy), eh);
            tx = qdiv(tx, ew);
            ty = qdiv(ty, eh);
        end
        r.sx = sx[31:0]; r.sy = sy[31:0]; r.tx = tx[31:0]; r.ty = ty[31:0];
        r.vv = valid;
        r.sat = clip_flag;
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h00FF_FFFF);
            2: return 32'h0000_1000 + $urandom_range(0, 32'h003F_FFFF);
            3: return -$signed($urandom_range(0, 32'h00FF_FFFF));
            4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                 : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.elem_x = rand_q();
        it.elem_y = rand_q();
        it.view_x = rand_q();
        it.view_y = rand_q();
        if ($urandom_range(0, 9) < 8) begin
            it.elem_width  = $urandom_range(1, 32'h0400_0000);
            it.elem_height = $urandom_range(1, 32'h0400_0000);
            it.view_width  = $urandom_range(1, 32'h0400_0000);
            it.view_height = $urandom_range(1, 32'h0400_0000);
        end else begin
            it.elem_width  = rand_q();
            it.elem_height = rand_q();
            it.view_width  = rand_q();
            it.view_height = rand_q();
        end
        it.normalize = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic t_item make_item(input logic [31:0] ex, ey, ew, eh, vx, vy, vw, vh,
                                        input logic nrm);
        t_item it;
        it.elem_x = ex; it.elem_y = ey; it.elem_width = ew; it.elem_height = eh;
        it.view_x = vx; it.view_y = vy; it.view_width = vw; it.view_height = vh;
        it.normalize = nrm;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_xforms.push_back(predict_xform(pending_items.pop_front()));
            end
            if (pending_items.size() > 0 && (i_valid && o_stall ||
                $urandom_range(0, 99) >= sender_idle_pct)) begin
                i_valid       <= 1'b1;
                i_elem_x      <= pending_items[0].elem_x;
                i_elem_y      <= pending_items[0].elem_y;
                i_elem_width  <= pending_items[0].elem_width;
                i_elem_height <= pending_items[0].elem_height;
                i_view_x      <= pending_items[0].view_x;
                i_view_y      <= pending_items[0].view_y;
                i_view_width  <= pending_items[0].view_width;
                i_view_height <= pending_items[0].view_height;
                i_normalize   <= pending_items[0].normalize;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_xform e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_xforms.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected transfer at %0t", $realtime);
                end else begin
                    e = expected_xforms.pop_front();
                    transforms_checked++;
                    if (o_scale_x !== e.sx || o_scale_y !== e.sy || o_shift_x !== e.tx ||
                        o_shift_y !== e.ty || o_view_valid !== e.vv ||
                        o_saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h %h %h %h %b %b, got %h %h %h %h %b %b",
                                     e.sx, e.sy, e.tx, e.ty, e.vv, e.sat, o_scale_x,
                                     o_scale_y, o_shift_x, o_shift_y, o_view_valid,
                                     o_saturated);
                    end
                end
            end
            if (hold_receiver > 0) begin
                hold_receiver <= hold_receiver - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("viewbox_to_viewport_transform_unit test failed");
                $finish;
            end
        end
    end

    task automatic drain_all();
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_xforms.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [3:0] data);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == REG_ALIGN_MODE) align_cfg = data;
        else slice_cfg = data[0];
    endtask

    task automatic add_random(input int n);
        repeat (n) pending_items.push_back(rand_item());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0; i_cfg_addr = 1'b0; i_cfg_wr_data = '0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_elem_x = '0; i_elem_y = '0; i_elem_width = '0; i_elem_height = '0;
        i_view_x = '0; i_view_y = '0; i_view_width = '0; i_view_height = '0;
        i_normalize = 1'b0;
        align_cfg = ALIGN_RESET; slice_cfg = 1'b0;
        sender_idle_pct = 8; receiver_idle_pct = 76;
        hold_receiver = 0; mismatches = 0; transforms_checked = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(0, 0, 32'h0064_0000, 32'h0032_0000,
                                          0, 0, 32'h000A_0000, 32'h000A_0000, 0));
        pending_items.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                          1, 1, 0));
        pending_items.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        pending_items.push_back(make_item(5, 6, 32'h0010_0000, 32'h0010_0000,
                                          1, 2, 0, 32'h0001_0000, 1));
        pending_items.push_back(make_item(5, 6, 32'h0010_0000, 32'h0010_0000,
                                          1, 2, 32'h0001_0000, 32'h8000_0000, 0));
        pending_items.push_back(make_item(5, 6, 32'hFFF0_0000, 32'h0010_0000,
                                          1, 2, 32'h0002_0000, 32'h0003_0000, 1));
        pending_items.push_back(make_item(5, 6, 0, 32'h0010_0000,
                                          1, 2, 32'h0002_0000, 32'h0003_0000, 1));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0001,
                                          32'h0003_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'h0000_0003, 32'h0007_0000, 1));
        pending_items.push_back(make_item(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          0, 0, 0, 0, 1));
        add_random(6);
        drain_all();

        for (int am = 0; am < 16; am++) begin
            write_reg(REG_ALIGN_MODE, am[3:0]);
            write_reg(REG_MEET_OR_SLICE, am[0]);
            add_random(am == 0 ? 8 : 4);
            drain_all();
        end

        write_reg(REG_ALIGN_MODE, 4'd9);
        write_reg(REG_MEET_OR_SLICE, 1'b1);
        add_random(400);
        wait (pending_items.size() < 300);
        hold_receiver = 400;
        drain_all();

        sender_idle_pct = 76; receiver_idle_pct = 8;
        write_reg(REG_ALIGN_MODE, 4'd1);
        write_reg(REG_MEET_OR_SLICE, 1'b0);
        add_random(400);
        drain_all();

        sender_idle_pct = 0; receiver_idle_pct = 0;
        write_reg(REG_ALIGN_MODE, 4'd0);
        add_random(300);
        drain_all();
        write_reg(REG_ALIGN_MODE, 4'd5);
        add_random(250);
        drain_all();

        $display("Checked %0d transforms over all alignment codes, meet and slice,",
                 transforms_checked);
        $display("edge rectangles, invalid view boxes and back-pressure phases.");
        if (mismatches == 0) begin
            $display("viewbox_to_viewport_transform_unit test passed");
        end else begin
            $display("viewbox_to_viewport_transform_unit test failed");
        end
        $finish;
    end
endmodule
